@@ rtl/core/heap_page_run_allocator_macros.svh @@
// assertion macros for the heap page-run allocator checker
`ifndef HEAP_PAGE_RUN_ALLOCATOR_MACROS_SVH
`define HEAP_PAGE_RUN_ALLOCATOR_MACROS_SVH
// property that holds unless reset is high
`define HPRA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked through reset as well
`define HPRA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/core/hpra_pkg.sv @@
// ----------------------------------------------------------------------------
// hpra_pkg
// Shared constants and types of the heap page-run allocator.
// ----------------------------------------------------------------------------
package hpra_pkg;
   localparam int DIR_COUNT     = 512;
   localparam int PAGES_PER_DIR = 512;
   localparam int TOTAL_PAGES   = DIR_COUNT * PAGES_PER_DIR;
   localparam int DIR_W         = $clog2(DIR_COUNT);
   localparam int PG_W          = $clog2(PAGES_PER_DIR);
   localparam int PAGE_W        = DIR_W + PG_W;
   localparam int CNT_W         = PAGE_W + 1;
   localparam int WORD_W        = 64;
   localparam int WORDS_PER_DIR = (PAGES_PER_DIR + WORD_W - 1) / WORD_W;

   typedef logic [1:0] func_type;
   localparam func_type FUNC_ALLOC = 2'd0;
   localparam func_type FUNC_FREE  = 2'd1;
   localparam func_type FUNC_LARGE = 2'd2;
   localparam func_type FUNC_MAP   = 2'd3;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_ABSENT = 2'd0;
   localparam mode_type MODE_TABLE  = 2'd1;
   localparam mode_type MODE_LARGE  = 2'd2;
endpackage

@@ rtl/core/heap_page_run_allocator.sv @@
// ----------------------------------------------------------------------------
// heap_page_run_allocator
// First-fit allocator of page runs over a window of page directories.
// ----------------------------------------------------------------------------
// One request enters on the req_ stream (func, start_page, count,
// map_present) and gives exactly one item on the rsp_ stream (status,
// alloc_page). req_tready is high only while the sequencer is idle.
// After reset a clearing pass sweeps the page map one page per cycle; no
// item is taken during the pass. The directory mode store is cleared
// within the same pass (address taken from the low pointer bits, so every
// directory is cleared while the pointer is still below DIR_COUNT).
// Free and map requests write the pages from start_page on, up to
// TOTAL_PAGES of them; map large marks directories, up to DIR_COUNT. Allocate
// first reads and checks each page of table-backed directories and skips
// other directories whole (pass one), then scans for a run of absent
// directories (pass two), then writes the pages of the run.
// The result waits in the output register while rsp_tready is low; the
// next request is taken in the cycle after that item has been delivered.
module heap_page_run_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] func, [19:2] start_page, [38:20] count, [39] map_present
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] status, [18:1] alloc_page
   output logic [23:0] rsp_tdata
);
   localparam int PW = hpra_pkg::PAGE_W;
   localparam int CW = hpra_pkg::CNT_W;
   localparam int DW = hpra_pkg::DIR_W;
   localparam int GW = hpra_pkg::PG_W;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_WRITE = 9'b000000100,
      ST_LARGE = 9'b000001000,
      ST_P1    = 9'b000010000,
      ST_P1CHK = 9'b000100000,
      ST_P2    = 9'b001000000,
      ST_MARK  = 9'b010000000,
      ST_RESP  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   hpra_pkg::mode_type dir_mode_mem [hpra_pkg::DIR_COUNT];
   hpra_pkg::mode_type dir_q_ff;        // mode of the directory at ptr_ff

   logic [PW-1:0] ptr_ff, ptr_in;       // page scan pointer
   logic [CW-1:0] left_ff, left_in;     // pages or dirs still to touch
   logic [CW-1:0] need_ff, need_in;
   logic [CW-1:0] run_ff, run_in;       // shared run counter
   logic [PW-1:0] start_ff, start_in;   // run start
   logic          bit_ff, bit_in;
   logic          stat_ff, stat_in;
   logic [PW-1:0] page_ff, page_in;
   logic          last_ff, last_in;     // pass-one page in flight was last

   logic          m_wr, m_rd, m_bit, m_q;
   logic [PW-1:0] m_addr;

   logic                      dir_we;
   logic [DW-1:0]             dir_waddr;
   logic [DW-1:0]             dir_raddr;
   hpra_pkg::mode_type        dir_wval;

   logic [DW-1:0] cur_dir;
   logic [CW-1:0] run_inc, need_eff;

   assign cur_dir   = ptr_ff[PW-1:GW];
   assign dir_raddr = ptr_in[PW-1:GW];
   assign need_eff  = (need_ff == '0) ? CW'(1) : need_ff;
   assign run_inc   = run_ff + CW'(hpra_pkg::PAGES_PER_DIR);

   hpra_page_map u_map (
      .clock     (clock),
      .wr_en     (m_wr),
      .rd_en     (m_rd),
      .addr      (m_addr),
      .wr_bit    (m_bit),
      .rd_bit_ff (m_q)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff; left_in = left_ff; need_in = need_ff; run_in = run_ff;
      start_in = start_ff; bit_in = bit_ff; stat_in = stat_ff;
      page_in = page_ff; last_in = last_ff;
      m_wr = 1'b0; m_rd = 1'b0; m_bit = 1'b0; m_addr = ptr_ff;
      dir_we = 1'b0; dir_waddr = cur_dir; dir_wval = hpra_pkg::MODE_TABLE;
      case (state_ff)
         ST_CLEAR: begin
            m_wr = 1'b1;
            dir_we = 1'b1; dir_waddr = ptr_ff[DW-1:0]; dir_wval = hpra_pkg::MODE_ABSENT;
            ptr_in = ptr_ff + PW'(1);
            if (ptr_ff == PW'(hpra_pkg::TOTAL_PAGES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               ptr_in  = req_tdata[19:2];
               need_in = req_tdata[38:20];
               stat_in = 1'b0;
               page_in = '0;
               run_in  = '0;
               case (hpra_pkg::func_type'(req_tdata[1:0]))
                  hpra_pkg::FUNC_ALLOC: begin
                     ptr_in = '0; start_in = '0; state_in = ST_P1;
                  end
                  hpra_pkg::FUNC_FREE: begin
                     bit_in = 1'b0;
                     left_in = (req_tdata[38:20] > CW'(hpra_pkg::TOTAL_PAGES)) ?
                               CW'(hpra_pkg::TOTAL_PAGES) : req_tdata[38:20];
                     state_in = ST_WRITE;
                  end
                  hpra_pkg::FUNC_LARGE: begin
                     left_in = (req_tdata[38:20] > CW'(hpra_pkg::DIR_COUNT)) ?
                               CW'(hpra_pkg::DIR_COUNT) : req_tdata[38:20];
                     state_in = ST_LARGE;
                  end
                  default: begin
                     bit_in = req_tdata[39];
                     left_in = (req_tdata[38:20] > CW'(hpra_pkg::TOTAL_PAGES)) ?
                               CW'(hpra_pkg::TOTAL_PAGES) : req_tdata[38:20];
                     state_in = ST_WRITE;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            if (left_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               m_wr = 1'b1; m_bit = bit_ff;
               ptr_in = ptr_ff + PW'(1);
               left_in = left_ff - CW'(1);
            end
         end
         ST_LARGE: begin
            if (left_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               dir_we = 1'b1; dir_wval = hpra_pkg::MODE_LARGE;
               ptr_in = {cur_dir + DW'(1), GW'(0)};
               left_in = left_ff - CW'(1);
            end
         end
         // pass one: issue read of page at ptr, or skip non-table directory
         ST_P1: begin
            if (dir_q_ff != hpra_pkg::MODE_TABLE) begin
               run_in = '0;
               start_in = {cur_dir + DW'(1), GW'(0)};
               ptr_in = {cur_dir + DW'(1), GW'(0)};
               if (cur_dir == DW'(hpra_pkg::DIR_COUNT - 1)) begin
                  ptr_in = '0; run_in = '0; start_in = '0; state_in = ST_P2;
               end
            end else begin
               m_rd = 1'b1;
               last_in = (ptr_ff == PW'(hpra_pkg::TOTAL_PAGES - 1));
               state_in = ST_P1CHK;
            end
         end
         ST_P1CHK: begin
            if (m_q) begin
               run_in = '0;
               start_in = ptr_ff + PW'(1);
            end else begin
               run_in = run_ff + CW'(1);
            end
            if (!m_q && (run_ff + CW'(1) >= need_eff)) begin
               page_in = start_ff;
               ptr_in = start_ff;
               left_in = run_ff + CW'(1);
               bit_in = 1'b1;
               state_in = ST_WRITE;
            end else if (last_ff) begin
               ptr_in = '0; run_in = '0; start_in = '0; state_in = ST_P2;
            end else begin
               ptr_in = ptr_ff + PW'(1);
               state_in = ST_P1;
            end
         end
         // pass two: one directory per cycle
         ST_P2: begin
            if (dir_q_ff != hpra_pkg::MODE_ABSENT) begin
               run_in = '0;
               start_in = {cur_dir + DW'(1), GW'(0)};
            end else if (run_inc >= need_ff) begin
               dir_we = 1'b1; dir_waddr = start_ff[PW-1:GW];
               page_in = start_ff;
               ptr_in = start_ff;
               left_in = need_ff;
               state_in = ST_MARK;
            end else begin
               run_in = run_inc;
            end
            if (state_in == ST_P2) begin
               ptr_in = {cur_dir + DW'(1), GW'(0)};
               if (cur_dir == DW'(hpra_pkg::DIR_COUNT - 1)) begin
                  stat_in = 1'b1; state_in = ST_RESP;
               end
            end
         end
         ST_MARK: begin
            if (left_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               m_wr = 1'b1; m_bit = 1'b1;
               dir_we = 1'b1;
               ptr_in = ptr_ff + PW'(1);
               left_in = left_ff - CW'(1);
               if (ptr_ff == PW'(hpra_pkg::TOTAL_PAGES - 1)) left_in = '0;
            end
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
   end

   // directory mode store, read ahead at the next scan pointer
   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mode_mem[dir_waddr] <= dir_wval;
      end
      dir_q_ff <= dir_mode_mem[dir_raddr];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      left_ff <= left_in; need_ff <= need_in; run_ff <= run_in;
      start_ff <= start_in; bit_ff <= bit_in; stat_ff <= stat_in;
      page_ff <= page_in; last_ff <= last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {5'd0, page_ff, stat_ff};
endmodule

@@ rtl/core/hpra_page_map.sv @@
// ----------------------------------------------------------------------------
// hpra_page_map
// Page used-bit store: one bit per page, single port, registered read.
// ----------------------------------------------------------------------------
module hpra_page_map (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic                          rd_en,
   input  logic [hpra_pkg::PAGE_W-1:0]   addr,
   input  logic                          wr_bit,
   output logic                          rd_bit_ff
);
   logic mem [hpra_pkg::TOTAL_PAGES];

   // write and registered read share the address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_bit;
      end
      if (rd_en) begin
         rd_bit_ff <= mem[addr];
      end
   end
endmodule

@@ rtl/core/hpra_checker.sv @@
// ----------------------------------------------------------------------------
// hpra_checker
// Port-level checks of the heap page-run allocator.
// ----------------------------------------------------------------------------
`include "heap_page_run_allocator_macros.svh"
module hpra_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   // never take a request while a result is pending
   `HPRA_ASSERT(a_excl, clock, reset, !(req_tready && rsp_tvalid), "ready with result")
   // an accepted request never answers in the next cycle
   `HPRA_ASSERT(a_lat, clock, reset, (req_tvalid && req_tready) |=> !rsp_tvalid, "early rsp")
   // a failed allocation reports page zero
   `HPRA_ASSERT(a_oom, clock, reset, (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[18:1] == 18'd0),
      "oom page")
   // padding stays zero
   `HPRA_ASSERT(a_pad, clock, reset, rsp_tvalid |-> (rsp_tdata[23:19] == 5'd0), "pad")
   // reset leaves both channels quiet
   `HPRA_ASSERT_ALWAYS(a_rst, clock, reset |=> (!rsp_tvalid && !req_tready), "reset")
endmodule

bind heap_page_run_allocator hpra_checker u_hpra_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

@@ bench/tb_heap_page_run_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_heap_page_run_allocator
// Self-checking bench for the first-fit heap page-run allocator.
// ----------------------------------------------------------------------------
// A shadow copy of the directory modes and the page map predicts the status
// and the start page of every request. Each response item is compared with
// the oldest prediction. Directed requests cover the corner cases first.
// Then a random mix of allocations, frees of live runs and map requests runs,
// with bursts of stalls on both streams.
// ----------------------------------------------------------------------------
module tb_heap_page_run_allocator;

   typedef struct packed {
      logic        status;
      logic [17:0] page;
   } alloc_result_type;

   typedef struct {
      int first;
      int pages;
   } live_run_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   // shadow state of the allocator
   hpra_pkg::mode_type shadow_mode [0:hpra_pkg::DIR_COUNT-1];
   bit                 shadow_used [0:hpra_pkg::TOTAL_PAGES-1];

   alloc_result_type pending_results [$];
   live_run_type     live_runs [$];

   int  errors = 0;
   int  n_alloc = 0;
   int  n_oom = 0;
   int  n_release = 0;
   int  n_map = 0;
   int  n_checked = 0;
   bit  quiet = 1'b0;
   int  rsp_stall = 0;

   heap_page_run_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // safety net against a hung block
   initial begin
      #400000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // write a run of used bits, wrapping at the window end
   task automatic write_used(input int first, input int n, input bit value);
      int p;
      int k;
      p = first % hpra_pkg::TOTAL_PAGES;
      if (n > hpra_pkg::TOTAL_PAGES) n = hpra_pkg::TOTAL_PAGES;
      for (k = 0; k < n; k++) begin
         shadow_used[p] = value;
         p = (p + 1) % hpra_pkg::TOTAL_PAGES;
      end
   endtask

   // first fit over free pages of table-backed directories
   task automatic fit_in_tables(input int need, output bit found, output int where);
      int run_first;
      int run_len;
      int idx;
      int k;
      found = 1'b0;
      where = 0;
      run_first = 0;
      run_len = 0;
      for (int d = 0; d < hpra_pkg::DIR_COUNT && !found; d++) begin
         if (shadow_mode[d] != hpra_pkg::MODE_TABLE) begin
            run_first = (d + 1) * hpra_pkg::PAGES_PER_DIR;
            run_len = 0;
         end else begin
            for (int pg = 0; pg < hpra_pkg::PAGES_PER_DIR && !found; pg++) begin
               idx = d * hpra_pkg::PAGES_PER_DIR + pg;
               if (shadow_used[idx]) begin
                  run_first = idx + 1;
                  run_len = 0;
               end else begin
                  run_len++;
                  if (run_len >= need) begin
                     for (k = 0; k < run_len; k++)
                        if (run_first + k < hpra_pkg::TOTAL_PAGES)
                           shadow_used[run_first + k] = 1'b1;
                     where = run_first;
                     found = 1'b1;
                  end
               end
            end
         end
      end
   endtask

   // first fit over absent directories
   task automatic fit_in_absent(input int need, output bit found, output int where);
      int first_dir;
      int run_len;
      int base;
      int p;
      found = 1'b0;
      where = 0;
      first_dir = 0;
      run_len = 0;
      for (int d = 0; d < hpra_pkg::DIR_COUNT && !found; d++) begin
         if (shadow_mode[d] != hpra_pkg::MODE_ABSENT) begin
            first_dir = d + 1;
            run_len = 0;
         end else begin
            run_len += hpra_pkg::PAGES_PER_DIR;
            if (run_len >= need) begin
               base = first_dir * hpra_pkg::PAGES_PER_DIR;
               shadow_mode[first_dir] = hpra_pkg::MODE_TABLE;
               for (int k = 0; k < need; k++) begin
                  p = base + k;
                  if (p >= hpra_pkg::TOTAL_PAGES) break;
                  shadow_mode[p / hpra_pkg::PAGES_PER_DIR] = hpra_pkg::MODE_TABLE;
                  shadow_used[p] = 1'b1;
               end
               where = base;
               found = 1'b1;
            end
         end
      end
   endtask

   // apply one request to the shadow state and give its response
   task automatic predict_request(input hpra_pkg::func_type func, input int start,
                                  input int count, input bit present,
                                  output alloc_result_type res);
      bit found;
      int where;
      int d;
      int n;
      res = '0;
      case (func)
         hpra_pkg::FUNC_ALLOC: begin
            fit_in_tables(count, found, where);
            if (!found) fit_in_absent(count, found, where);
            if (found) res.page = where[17:0];
            else res.status = 1'b1;
         end
         hpra_pkg::FUNC_FREE: write_used(start, count, 1'b0);
         hpra_pkg::FUNC_LARGE: begin
            d = (start / hpra_pkg::PAGES_PER_DIR) % hpra_pkg::DIR_COUNT;
            n = (count > hpra_pkg::DIR_COUNT) ? hpra_pkg::DIR_COUNT : count;
            for (int k = 0; k < n; k++) begin
               shadow_mode[d] = hpra_pkg::MODE_LARGE;
               d = (d + 1) % hpra_pkg::DIR_COUNT;
            end
         end
         default: write_used(start, count, present);
      endcase
   endtask

   function automatic int idle_gap();
      if (quiet || $urandom_range(0, 2) != 0) return 0;
      return $urandom_range(1, 12);
   endfunction

   // send one request item and record its predicted response
   task automatic send_request(input hpra_pkg::func_type func, input int start,
                               input int count, input bit present,
                               output alloc_result_type res);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {present, count[18:0], start[17:0], func};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(func, start, count, present, res);
      pending_results.push_back(res);
      case (func)
         hpra_pkg::FUNC_ALLOC: begin
            n_alloc++;
            if (res.status) n_oom++;
         end
         hpra_pkg::FUNC_FREE: n_release++;
         default: n_map++;
      endcase
   endtask

   // response stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         rsp_stall  <= $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each response item with the oldest prediction
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response item status=%0b page=%0d", $time,
                     rsp_tdata[0], rsp_tdata[18:1]);
            errors++;
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (rsp_tdata[0] !== want.status) begin
               $display("%0t: status expected %0b actual %0b", $time, want.status,
                        rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[18:1] !== want.page) begin
               $display("%0t: alloc_page expected %0d actual %0d", $time, want.page,
                        rsp_tdata[18:1]);
               errors++;
            end
         end
      end
   end

   // allocate and keep the run for a later free
   task automatic alloc_and_track(input int count);
      alloc_result_type res;
      live_run_type run;
      send_request(hpra_pkg::FUNC_ALLOC, $urandom_range(0, hpra_pkg::TOTAL_PAGES - 1), count,
                   $urandom_range(0, 1), res);
      if (!res.status && count > 0) begin
         run.first = res.page;
         run.pages = count;
         live_runs.push_back(run);
      end
   endtask

   // corner cases: zero count, oversize, wrapping, mode overwrite
   task automatic test_directed();
      alloc_result_type res;
      alloc_and_track(1);
      send_request(hpra_pkg::FUNC_ALLOC, 0, 0, 1'b0, res);
      alloc_and_track(512);
      alloc_and_track(1000);
      send_request(hpra_pkg::FUNC_ALLOC, hpra_pkg::TOTAL_PAGES - 1, 19'h7FFFF, 1'b1, res);
      send_request(hpra_pkg::FUNC_ALLOC, 0, 262144, 1'b0, res);
      send_request(hpra_pkg::FUNC_MAP, hpra_pkg::TOTAL_PAGES - 1, 3, 1'b1, res);
      send_request(hpra_pkg::FUNC_MAP, 700, 20, 1'b1, res);
      alloc_and_track(30);
      send_request(hpra_pkg::FUNC_MAP, 705, 4, 1'b0, res);
      alloc_and_track(3);
      send_request(hpra_pkg::FUNC_LARGE, hpra_pkg::TOTAL_PAGES - 1, 2, 1'b0, res);
      alloc_and_track(5);
      send_request(hpra_pkg::FUNC_MAP, 3 * hpra_pkg::PAGES_PER_DIR, 2, 1'b1, res);
      send_request(hpra_pkg::FUNC_LARGE, 2 * hpra_pkg::PAGES_PER_DIR + 7, 1, 1'b0, res);
      send_request(hpra_pkg::FUNC_MAP, 2 * hpra_pkg::PAGES_PER_DIR, 6, 1'b1, res);
      send_request(hpra_pkg::FUNC_FREE, 5, 19'h7FFFF, 1'b0, res);
      send_request(hpra_pkg::FUNC_FREE, hpra_pkg::TOTAL_PAGES - 2, 262144, 1'b0, res);
      live_runs.delete();
      alloc_and_track(0);
      alloc_and_track(2);
   endtask

   // random mix of allocations, frees of live runs and maps
   task automatic test_random(input int items);
      alloc_result_type res;
      live_run_type run;
      int pick;
      int idx;
      for (int i = 0; i < items; i++) begin
         quiet = (i >= items - 60);
         pick = $urandom_range(0, 99);
         if (live_runs.size() > 8 || (pick < 25 && live_runs.size() > 0)) begin
            idx = $urandom_range(0, live_runs.size() - 1);
            run = live_runs[idx];
            live_runs.delete(idx);
            send_request(hpra_pkg::FUNC_FREE, run.first, run.pages, $urandom_range(0, 1), res);
         end else if (pick < 75) begin
            case ($urandom_range(0, 9))
               0: alloc_and_track($urandom_range(0, 1) ? 0 : $urandom_range(700, 1600));
               1, 2: alloc_and_track($urandom_range(65, 700));
               default: alloc_and_track($urandom_range(1, 64));
            endcase
         end else if (pick < 93) begin
            send_request(hpra_pkg::FUNC_MAP, $urandom_range(0, hpra_pkg::TOTAL_PAGES - 1),
                         $urandom_range(1, 40), $urandom_range(0, 1), res);
         end else if (pick < 96) begin
            send_request(hpra_pkg::FUNC_LARGE, $urandom_range(0, hpra_pkg::TOTAL_PAGES - 1),
                         $urandom_range(1, 2), 1'b0, res);
         end else begin
            send_request(hpra_pkg::FUNC_FREE, $urandom_range(0, hpra_pkg::TOTAL_PAGES - 1),
                         $urandom_range(1, 64), 1'b0, res);
         end
      end
   endtask

   // whole window made large, then an allocation must fail
   task automatic test_full_large();
      alloc_result_type res;
      send_request(hpra_pkg::FUNC_LARGE, $urandom_range(0, hpra_pkg::TOTAL_PAGES - 1),
                   19'h7FFFF, 1'b0, res);
      send_request(hpra_pkg::FUNC_ALLOC, 0, 1, 1'b0, res);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int d = 0; d < hpra_pkg::DIR_COUNT; d++) shadow_mode[d] = hpra_pkg::MODE_ABSENT;
      for (int p = 0; p < hpra_pkg::TOTAL_PAGES; p++) shadow_used[p] = 1'b0;
      test_directed();
      test_random(555);
      test_full_large();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d allocations (%0d out of memory), %0d frees, %0d map requests",
               n_alloc, n_oom, n_release, n_map);
      $display("%0d response items checked, %0d mismatches", n_checked, errors);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
